// ===== rtl/eocc_pkg.sv =====
// ----------------------------------------------------------------------------
// eocc_pkg
// Shared constants and types for the segment-versus-obstacle collision check.
// ----------------------------------------------------------------------------
package eocc_pkg;

  // Width of the obstacles-in-use register
  localparam int CFG_W  = 5;
  // Width of the obstacle slot field
  localparam int SLOT_W = 4;

  // Control word that travels alongside the side-test pipeline
  typedef struct packed {
    logic valid;   // an obstacle step occupies this stage
    logic in_use;  // the obstacle at this step counts toward the result
    logic last;    // final step of the current check
  } ctl_t;

endpackage

// ===== rtl/eocc_cell.sv =====
// ----------------------------------------------------------------------------
// eocc_cell
// One obstacle slot of the ring: loads a written obstacle or takes its
// neighbor's obstacle while a check rotates the ring.
// ----------------------------------------------------------------------------
module eocc_cell #(
  parameter int W = 64
) (
  input  logic         clk_i,
  input  logic         wr_en_i,
  input  logic [W-1:0] wr_data_i,
  input  logic         shift_en_i,
  input  logic [W-1:0] shift_data_i,
  output logic [W-1:0] data_o
);

  logic [W-1:0] obst_q;
  logic [W-1:0] obst_d;

  // Load a write, advance during a scan, otherwise hold
  always_comb begin
    obst_d = obst_q;
    if (wr_en_i) begin
      obst_d = wr_data_i;
    end else if (shift_en_i) begin
      obst_d = shift_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    obst_q <= obst_d;
  end

  assign data_o = obst_q;

endmodule

// ===== rtl/eocc_side.sv =====
// ----------------------------------------------------------------------------
// eocc_side
// Exact crossing test of a segment against one vertical rectangle side.
// Horizontal sides use the same test with x and y swapped by the caller.
// Three stages: products, cross terms, range compare.
// ----------------------------------------------------------------------------
module eocc_side #(
  parameter int DW = 17
) (
  input  logic                 clk_i,
  input  logic signed [DW-1:0] sx_i,   // segment direction x
  input  logic signed [DW-1:0] sy_i,   // segment direction y
  input  logic signed [DW-1:0] ox_i,   // segment start minus side start, x
  input  logic signed [DW-1:0] oy_i,   // segment start minus side start, y
  input  logic signed [DW-1:0] ey_i,   // side extent along y
  output logic                 hit_o
);

  localparam int PW = 2 * DW;

  logic signed [PW-1:0] m0_q, m1_q, m2_q, m3_q;
  logic signed [PW-1:0] d_q, q1_q, q2_q;
  logic                 hit_q;
  logic                 hit_d;

  // True when q/d lies in [0,1]; d is known nonzero
  function automatic logic ratio_ok(input logic signed [PW-1:0] q,
                                    input logic signed [PW-1:0] d);
    logic q_ge0;
    logic q_le0;
    begin
      q_ge0 = ~q[PW-1];
      q_le0 = q[PW-1] | (q == '0);
      if (~d[PW-1]) begin
        ratio_ok = q_ge0 & (q <= d);
      end else begin
        ratio_ok = q_le0 & (q >= d);
      end
    end
  endfunction

  // Stage 1: products (the side has no x extent)
  always_ff @(posedge clk_i) begin
    m0_q <= sx_i * ey_i;
    m1_q <= ox_i * ey_i;
    m2_q <= oy_i * sx_i;
    m3_q <= ox_i * sy_i;
  end

  // Stage 2: d = s x e, q1 = -(ox*ey), q2 = s x o
  always_ff @(posedge clk_i) begin
    d_q  <= m0_q;
    q1_q <= -m1_q;
    q2_q <= m2_q - m3_q;
  end

  // Stage 3: both ratios inside the unit interval
  always_comb begin
    hit_d = (d_q != '0) & ratio_ok(q1_q, d_q) & ratio_ok(q2_q, d_q);
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
  end

  assign hit_o = hit_q;

endmodule

// ===== rtl/edge_obstacle_collision_check.sv =====
// ----------------------------------------------------------------------------
// edge_obstacle_collision_check
// Tests a line segment against a table of axis-aligned rectangular obstacles.
// ----------------------------------------------------------------------------
// Start a transaction by raising start while busy is low. With mode_i low
// it stores an obstacle in slot_i in that cycle and gives no result; busy
// stays low, so writes may follow back to back. With mode_i high it checks
// the segment: busy rises, the obstacle ring rotates one slot per clock
// past a four-side test unit, and after the last step leaves the side
// tests done_o pulses for exactly one cycle with collides_o. The receiver
// cannot stall, so capture collides_o on that cycle. busy falls together
// with done_o; the length of a check is set by the ring length plus the
// four-stage side-test pipeline. cfg_ready_o is low while busy, so
// obstacles_in_use written through cfg_valid_i/cfg_data_i only changes
// between checks; values above MAX_OBSTACLES act as MAX_OBSTACLES. Slots
// in use must have been written.
// ----------------------------------------------------------------------------
module edge_obstacle_collision_check #(
  parameter int MAX_OBSTACLES = 16,
  parameter int COORD_BITS    = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode_i,
  input  logic [eocc_pkg::SLOT_W-1:0] slot_i,
  input  logic [COORD_BITS-1:0]       first_x_i,
  input  logic [COORD_BITS-1:0]       first_y_i,
  input  logic [COORD_BITS-1:0]       second_x_i,
  input  logic [COORD_BITS-1:0]       second_y_i,
  output logic                        done_o,
  output logic                        collides_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [eocc_pkg::CFG_W-1:0]  cfg_data_i
);

  import eocc_pkg::*;

  localparam int DW     = COORD_BITS + 1;
  localparam int OW     = 4 * COORD_BITS;
  localparam int CNT_W  = $clog2(MAX_OBSTACLES + 1);
  localparam int CW     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int SW     = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
  localparam int NSIDE  = 4;
  localparam int NSTAGE = 4;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] step_q, step_d;
  logic [CFG_W-1:0] in_use_q;
  logic             acc_q, acc_d;
  logic             done_q, done_d;
  logic             collides_q, collides_d;
  ctl_t             ctl_q [NSTAGE];
  ctl_t             ctl_d0;

  logic             accept;
  logic             wr_item;
  logic             chk_item;
  logic             scan;
  logic             step_last;
  logic             side_any;

  // Segment held for the whole check
  logic [COORD_BITS-1:0] p1x_q, p1y_q;
  logic signed [DW-1:0]  sx_q, sy_q;

  // Head-of-ring obstacle corners
  logic [COORD_BITS-1:0] ax, ay, bx, by;

  // Per-side test inputs, vertical form
  logic signed [DW-1:0] s_sx [NSIDE];
  logic signed [DW-1:0] s_sy [NSIDE];
  logic signed [DW-1:0] s_ox_q [NSIDE];
  logic signed [DW-1:0] s_oy_q [NSIDE];
  logic signed [DW-1:0] s_ey_q [NSIDE];
  logic [NSIDE-1:0]     side_hit;

  logic [OW-1:0] cell_data [MAX_OBSTACLES];
  logic [OW-1:0] wr_data;

  assign accept   = start & ~busy;
  assign wr_item  = accept & ~mode_i;
  assign chk_item = accept & mode_i;
  assign scan     = (state_q == ST_SCAN);
  assign wr_data  = {second_y_i, second_x_i, first_y_i, first_x_i};

  // Obstacle ring: cell 0 is the head seen by the side tests
  for (genvar i = 0; i < MAX_OBSTACLES; i++) begin : g_cell
    localparam int NXT = (i + 1) % MAX_OBSTACLES;
    logic wr_en;

    assign wr_en = wr_item & (SW'(slot_i) == SW'(i));

    eocc_cell #(
      .W (OW)
    ) u_cell (
      .clk_i        (clk_i),
      .wr_en_i      (wr_en),
      .wr_data_i    (wr_data),
      .shift_en_i   (scan),
      .shift_data_i (cell_data[NXT]),
      .data_o       (cell_data[i])
    );
  end

  assign ax = cell_data[0][COORD_BITS-1:0];
  assign ay = cell_data[0][2*COORD_BITS-1:COORD_BITS];
  assign bx = cell_data[0][3*COORD_BITS-1:2*COORD_BITS];
  assign by = cell_data[0][4*COORD_BITS-1:3*COORD_BITS];

  // Capture the segment on a check transaction
  always_ff @(posedge clk_i) begin
    if (chk_item) begin
      p1x_q <= first_x_i;
      p1y_q <= first_y_i;
      sx_q  <= $signed(DW'(second_x_i)) - $signed(DW'(first_x_i));
      sy_q  <= $signed(DW'(second_y_i)) - $signed(DW'(first_y_i));
    end
  end

  // Offsets and extents for the four sides; horizontal sides swap x and y
  always_ff @(posedge clk_i) begin
    // side 0: (ax,ay) to (ax,by)
    s_ox_q[0] <= $signed(DW'(p1x_q)) - $signed(DW'(ax));
    s_oy_q[0] <= $signed(DW'(p1y_q)) - $signed(DW'(ay));
    s_ey_q[0] <= $signed(DW'(by)) - $signed(DW'(ay));
    // side 1: (ax,by) to (bx,by)
    s_ox_q[1] <= $signed(DW'(p1y_q)) - $signed(DW'(by));
    s_oy_q[1] <= $signed(DW'(p1x_q)) - $signed(DW'(ax));
    s_ey_q[1] <= $signed(DW'(bx)) - $signed(DW'(ax));
    // side 2: (bx,by) to (bx,ay)
    s_ox_q[2] <= $signed(DW'(p1x_q)) - $signed(DW'(bx));
    s_oy_q[2] <= $signed(DW'(p1y_q)) - $signed(DW'(by));
    s_ey_q[2] <= $signed(DW'(ay)) - $signed(DW'(by));
    // side 3: (bx,ay) to (ax,ay)
    s_ox_q[3] <= $signed(DW'(p1y_q)) - $signed(DW'(ay));
    s_oy_q[3] <= $signed(DW'(p1x_q)) - $signed(DW'(bx));
    s_ey_q[3] <= $signed(DW'(ax)) - $signed(DW'(bx));
  end

  assign s_sx[0] = sx_q;
  assign s_sy[0] = sy_q;
  assign s_sx[1] = sy_q;
  assign s_sy[1] = sx_q;
  assign s_sx[2] = sx_q;
  assign s_sy[2] = sy_q;
  assign s_sx[3] = sy_q;
  assign s_sy[3] = sx_q;

  for (genvar k = 0; k < NSIDE; k++) begin : g_side
    eocc_side #(
      .DW (DW)
    ) u_side (
      .clk_i (clk_i),
      .sx_i  (s_sx[k]),
      .sy_i  (s_sy[k]),
      .ox_i  (s_ox_q[k]),
      .oy_i  (s_oy_q[k]),
      .ey_i  (s_ey_q[k]),
      .hit_o (side_hit[k])
    );
  end

  assign side_any  = ctl_q[NSTAGE-1].valid & ctl_q[NSTAGE-1].in_use & (|side_hit);
  assign step_last = (step_q == CNT_W'(MAX_OBSTACLES - 1));

  // Issue one ring step per cycle while scanning
  always_comb begin
    ctl_d0.valid  = scan;
    ctl_d0.in_use = (CW'(step_q) < CW'(in_use_q));
    ctl_d0.last   = step_last;
  end

  // Sequence the scan, accumulate hits, present the result
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    acc_d      = acc_q | side_any;
    done_d     = 1'b0;
    collides_d = collides_q;
    case (state_q)
      ST_IDLE: begin
        if (chk_item) begin
          state_d = ST_SCAN;
          step_d  = '0;
          acc_d   = 1'b0;
        end
      end
      ST_SCAN: begin
        step_d = step_q + CNT_W'(1);
        if (step_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (ctl_q[NSTAGE-1].valid && ctl_q[NSTAGE-1].last) begin
          state_d    = ST_IDLE;
          done_d     = 1'b1;
          collides_d = acc_q | side_any;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      step_q     <= '0;
      acc_q      <= 1'b0;
      done_q     <= 1'b0;
      collides_q <= 1'b0;
      in_use_q   <= '0;
      for (int s = 0; s < NSTAGE; s++) begin
        ctl_q[s] <= '0;
      end
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      acc_q      <= acc_d;
      done_q     <= done_d;
      collides_q <= collides_d;
      if (cfg_valid_i && cfg_ready_o) begin
        in_use_q <= cfg_data_i;
      end
      ctl_q[0] <= ctl_d0;
      for (int s = 1; s < NSTAGE; s++) begin
        ctl_q[s] <= ctl_q[s-1];
      end
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign collides_o  = collides_q;
  // Hold configuration off while a check is in flight
  assign cfg_ready_o = ~busy;

endmodule

// ===== verif/edge_obstacle_collision_check_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_obstacle_collision_check_tb
// Self-checking bench for the segment-versus-obstacle collision check.
// ----------------------------------------------------------------------------
// A short table of hand-picked obstacles and segments runs first. It covers
// field extremes, degenerate rectangles, zero-length and collinear segments,
// touching endpoints, the ignored slot field and an empty obstacle set. A
// random run follows, over several settings of the in-use count (saturation
// included) and several sender idle rates. Segments are mostly aimed at
// obstacles in use. Every check transaction is predicted, from the row's flag
// where a table row gives one and else with exact integer side tests, and the
// prediction is compared with the collides strobe.
module edge_obstacle_collision_check_tb;

  localparam int MAX_OBS    = 16;
  localparam int COORD_W    = 16;
  localparam int N_DIRECTED = 19;
  localparam int N_PHASES   = 8;
  localparam int PHASE_OPS  = 128;
  localparam int SETTLE     = MAX_OBS + 8;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_CHECK = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [3:0]         slot;
    logic [COORD_W-1:0] fx;
    logic [COORD_W-1:0] fy;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
  } op_t;

  typedef struct packed {
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
  } obst_rec_t;

  // One table row: optional in-use write before the transaction, then the op
  typedef struct packed {
    logic                      cfg_en;
    logic [eocc_pkg::CFG_W-1:0] cfg_val;
    op_t                       op;
    logic                      hit_known;
    logic                      hit;
  } stim_row_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic                        mode_i;
  logic [eocc_pkg::SLOT_W-1:0] slot_i;
  logic [COORD_W-1:0]          first_x_i;
  logic [COORD_W-1:0]          first_y_i;
  logic [COORD_W-1:0]          second_x_i;
  logic [COORD_W-1:0]          second_y_i;
  logic                        done_o;
  logic                        collides_o;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [eocc_pkg::CFG_W-1:0]  cfg_data_i;

  // Predictor state
  obst_rec_t                  obstacle_q [MAX_OBS];
  logic [eocc_pkg::CFG_W-1:0] in_use_q;
  logic                       collide_expect_q[$];
  int                         mismatch_count;
  int                         sender_idle_pct;

  stim_row_t stim_table [N_DIRECTED] = '{
    // nothing in use yet: full-field diagonal sees no obstacle
    '{1'b0, 5'd0,  '{MODE_CHECK, 4'd0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF}, 1'b1, 1'b0},
    '{1'b0, 5'd0,  '{MODE_WRITE, 4'd0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF}, 1'b0, 1'b0},
    '{1'b0, 5'd0,  '{MODE_WRITE, 4'd1, 16'd32,   16'd32,   16'd16,   16'd16},   1'b0, 1'b0},
    // zero-width rectangle
    '{1'b0, 5'd0,  '{MODE_WRITE, 4'd2, 16'd100,  16'd200,  16'd100,  16'd900},  1'b0, 1'b0},
    '{1'b0, 5'd0,  '{MODE_WRITE, 4'd3, 16'hFFFF, 16'h0000, 16'h8000, 16'hFFFF}, 1'b0, 1'b0},
    '{1'b1, 5'd4,  '{MODE_CHECK, 4'd0, 16'h0000, 16'h8000, 16'hFFFF, 16'h8000}, 1'b0, 1'b0},
    // zero-length segment is parallel to every side
    '{1'b0, 5'd0,  '{MODE_CHECK, 4'd0, 16'd500,  16'd500,  16'd500,  16'd500},  1'b1, 1'b0},
    // along the top side of the full-field obstacle
    '{1'b0, 5'd0,  '{MODE_CHECK, 4'd0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF}, 1'b0, 1'b0},
    '{1'b0, 5'd0,  '{MODE_CHECK, 4'd0, 16'd50,   16'd150,  16'd150,  16'd950},  1'b0, 1'b0},
    '{1'b1, 5'd1,  '{MODE_CHECK, 4'd0, 16'd1,    16'd1,    16'd2,    16'd2},    1'b0, 1'b0},
    '{1'b0, 5'd0,  '{MODE_CHECK, 4'd0, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000}, 1'b0, 1'b0},
    '{1'b1, 5'd0,  '{MODE_CHECK, 4'd0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF}, 1'b1, 1'b0},
    '{1'b0, 5'd0,  '{MODE_WRITE, 4'd0, 16'd40,   16'd40,   16'd80,   16'd80},   1'b0, 1'b0},
    '{1'b1, 5'd2,  '{MODE_CHECK, 4'd0, 16'd0,    16'd60,   16'd200,  16'd60},   1'b0, 1'b0},
    // stop one short of the bottom side, then touch it
    '{1'b0, 5'd0,  '{MODE_CHECK, 4'd0, 16'd60,   16'd0,    16'd60,   16'd39},   1'b0, 1'b0},
    '{1'b0, 5'd0,  '{MODE_CHECK, 4'd0, 16'd60,   16'd0,    16'd60,   16'd40},   1'b0, 1'b0},
    // slot field is ignored by a check
    '{1'b0, 5'd0,  '{MODE_CHECK, 4'd15, 16'h8000, 16'h8000, 16'h8000, 16'h8001}, 1'b0, 1'b0},
    '{1'b0, 5'd0,  '{MODE_WRITE, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, 1'b0},
    '{1'b0, 5'd0,  '{MODE_CHECK, 4'd0, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF}, 1'b0, 1'b0}
  };

  edge_obstacle_collision_check #(
    .MAX_OBSTACLES(MAX_OBS),
    .COORD_BITS   (COORD_W)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .mode_i     (mode_i),
    .slot_i     (slot_i),
    .first_x_i  (first_x_i),
    .first_y_i  (first_y_i),
    .second_x_i (second_x_i),
    .second_y_i (second_y_i),
    .done_o     (done_o),
    .collides_o (collides_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // True when q/d lies in [0,1]; d is known to be nonzero
  function automatic bit ratio_in_unit(input longint q, input longint d);
    if (d > 0) return (q >= 0) && (q <= d);
    return (q <= 0) && (q >= d);
  endfunction

  // Exact crossing test of segment P1-P2 against side A-B
  function automatic bit side_crossed(input longint p1x, input longint p1y,
                                      input longint p2x, input longint p2y,
                                      input longint ax, input longint ay,
                                      input longint bx, input longint by);
    longint dx, dy, ex, ey, ox, oy, d, q1, q2;
    dx = p2x - p1x;
    dy = p2y - p1y;
    ex = bx - ax;
    ey = by - ay;
    ox = p1x - ax;
    oy = p1y - ay;
    d  = dx * ey - dy * ex;
    if (d == 0) return 1'b0;
    q1 = oy * ex - ox * ey;
    q2 = oy * dx - ox * dy;
    return ratio_in_unit(q1, d) && ratio_in_unit(q2, d);
  endfunction

  // Collision flag for a segment against the obstacles in use
  function automatic logic predict_collision(input op_t op);
    int     limit;
    longint p1x, p1y, p2x, p2y, ax, ay, bx, by;
    p1x   = op.fx;
    p1y   = op.fy;
    p2x   = op.sx;
    p2y   = op.sy;
    limit = (in_use_q > MAX_OBS) ? MAX_OBS : int'(in_use_q);
    for (int i = 0; i < limit; i++) begin
      ax = obstacle_q[i].ax;
      ay = obstacle_q[i].ay;
      bx = obstacle_q[i].bx;
      by = obstacle_q[i].by;
      if (side_crossed(p1x, p1y, p2x, p2y, ax, ay, ax, by) ||
          side_crossed(p1x, p1y, p2x, p2y, ax, by, bx, by) ||
          side_crossed(p1x, p1y, p2x, p2y, bx, by, bx, ay) ||
          side_crossed(p1x, p1y, p2x, p2y, bx, ay, ax, ay)) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return COORD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Jitter a coordinate by up to +/- span, clamped to the field
  function automatic logic [COORD_W-1:0] near(input logic [COORD_W-1:0] c,
                                              input int span);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    else if (v > 65535) v = 65535;
    return COORD_W'(v);
  endfunction

  function automatic logic [3:0] SLOT_RAND();
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic op_t random_op();
    op_t       op;
    obst_rec_t ob;
    int        limit;
    op.slot = SLOT_RAND();
    limit   = (in_use_q > MAX_OBS) ? MAX_OBS : int'(in_use_q);
    if ($urandom_range(0, 99) < 35) begin
      // obstacle: large, small or degenerate
      op.mode = MODE_WRITE;
      op.fx   = rand_coord();
      op.fy   = rand_coord();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          op.sx = rand_coord();
          op.sy = rand_coord();
        end
        5, 6, 7: begin
          op.sx = near(op.fx, 256);
          op.sy = near(op.fy, 256);
        end
        8: begin
          op.sx = op.fx;
          op.sy = near(op.fy, 256);
        end
        default: begin
          op.sx = near(op.fx, 256);
          op.sy = ($urandom_range(0, 1) != 0) ? op.fy : near(op.fy, 256);
          if (op.sy == op.fy && $urandom_range(0, 1) != 0) op.sx = op.fx;
        end
      endcase
    end else begin
      op.mode = MODE_CHECK;
      if (limit > 0 && $urandom_range(0, 99) < 60) begin
        // aim at the corners of an obstacle in use
        ob    = obstacle_q[$urandom_range(0, limit - 1)];
        op.fx = near(($urandom_range(0, 1) != 0) ? ob.ax : ob.bx, 300);
        op.fy = near(($urandom_range(0, 1) != 0) ? ob.ay : ob.by, 300);
        op.sx = near(($urandom_range(0, 1) != 0) ? ob.ax : ob.bx, 300);
        op.sy = near(($urandom_range(0, 1) != 0) ? ob.ay : ob.by, 300);
      end else begin
        op.fx = rand_coord();
        op.fy = rand_coord();
        op.sx = rand_coord();
        op.sy = rand_coord();
      end
      case ($urandom_range(0, 9))
        0, 1: op.sy = op.fy;
        2:    op.sx = op.fx;
        3: begin
          op.sx = op.fx;
          op.sy = op.fy;
        end
        default: ;
      endcase
    end
    return op;
  endfunction

  // Present one transaction and wait until the block takes it
  task automatic issue(input op_t op, input logic hit_known, input logic hit);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    start      <= 1'b1;
    mode_i     <= op.mode;
    slot_i     <= op.slot;
    first_x_i  <= op.fx;
    first_y_i  <= op.fy;
    second_x_i <= op.sx;
    second_y_i <= op.sy;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // accepted at this edge: advance the predictor
    if (op.mode == MODE_WRITE) begin
      obstacle_q[op.slot] = '{op.fx, op.fy, op.sx, op.sy};
    end else begin
      collide_expect_q.push_back(hit_known ? hit : predict_collision(op));
    end
  endtask

  // Drop start, drain all pending checks, let the pipeline settle
  task automatic drain();
    start <= 1'b0;
    while (collide_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_in_use(input logic [eocc_pkg::CFG_W-1:0] count);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= count;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    in_use_q = count;
  endtask

  // Compare each collides strobe with the oldest pending check
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (collide_expect_q.size() == 0) begin
        $error("collides: result %0b with no check pending", collides_o);
        mismatch_count++;
      end else begin
        if (collides_o !== collide_expect_q[0]) begin
          $error("collides mismatch: expected %0b, actual %0b",
                 collide_expect_q[0], collides_o);
          mismatch_count++;
        end
        void'(collide_expect_q.pop_front());
      end
    end
  end

  // Stimulus
  initial begin
    logic [eocc_pkg::CFG_W-1:0] phase_in_use [N_PHASES];
    int                         idle_pcts [3];
    op_t                        op;
    phase_in_use = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd17, 5'd16, 5'd3, 5'd31};
    idle_pcts    = '{0, 76, 14};
    rst_ni          <= 1'b0;
    start           <= 1'b0;
    mode_i          <= MODE_WRITE;
    slot_i          <= '0;
    first_x_i       <= '0;
    first_y_i       <= '0;
    second_x_i      <= '0;
    second_y_i      <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_data_i      <= '0;
    in_use_q        = '0;
    mismatch_count  = 0;
    sender_idle_pct = 14;
    for (int i = 0; i < MAX_OBS; i++) obstacle_q[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (stim_table[i]) begin
      if (stim_table[i].cfg_en) write_in_use(stim_table[i].cfg_val);
      issue(stim_table[i].op, stim_table[i].hit_known, stim_table[i].hit);
    end

    // fill every slot before any wide in-use setting
    sender_idle_pct = 0;
    for (int s = 0; s < MAX_OBS; s++) begin
      op      = random_op();
      op.mode = MODE_WRITE;
      op.slot = 4'(s);
      issue(op, 1'b0, 1'b0);
    end

    // random phases
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph == 6) write_in_use(5'($urandom_range(0, 31)));
      else write_in_use(phase_in_use[ph]);
      sender_idle_pct = idle_pcts[ph % 3];
      for (int n = 0; n < PHASE_OPS; n++) begin
        issue(random_op(), 1'b0, 1'b0);
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
